@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Constants and calendar helpers shared by the seconds-to-calendar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package stc_pkg;

	localparam int unsigned IN_W    = 32;
	localparam int unsigned DAYS_W  = 16;
	localparam int unsigned YEAR_W  = 8;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned SEC_W   = 6;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned ALU_W   = 16;

	localparam logic [IN_W-1:0]   DIV60_MAGIC    = 32'h8888_8889;
	localparam logic [IN_W-1:0]   DIV24_MAGIC    = 32'hAAAA_AAAB;
	localparam int unsigned       DIV60_SHIFT    = 37;
	localparam int unsigned       DIV24_SHIFT    = 36;
	localparam logic [ALU_W-1:0]  YEAR_DAYS      = 16'd365;
	localparam logic [ALU_W-1:0]  LEAP_YEAR_DAYS = 16'd366;
	localparam logic [ALU_W-1:0]  QUAD_DAYS      = 16'd1461;
	localparam logic [ALU_W-1:0]  QUAD_DAYS_NOLEAP = 16'd1460;
	localparam logic [YEAR_W-1:0] CENTURY_OFF    = 8'd100;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd11;

	function automatic logic is_leap(input logic [YEAR_W-1:0] yoff);
		is_leap = (yoff[1:0] == 2'b00) && (yoff != CENTURY_OFF);
	endfunction

	function automatic logic [ALU_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [ALU_W-1:0] len;
		unique case (m)
			4'd0:    len = 16'd31;
			4'd1:    len = leap ? 16'd29 : 16'd28;
			4'd2:    len = 16'd31;
			4'd3:    len = 16'd30;
			4'd4:    len = 16'd31;
			4'd5:    len = 16'd30;
			4'd6:    len = 16'd31;
			4'd7:    len = 16'd31;
			4'd8:    len = 16'd30;
			4'd9:    len = 16'd31;
			4'd10:   len = 16'd30;
			default: len = 16'd31;
		endcase
		month_len = len;
	endfunction

endpackage

`default_nettype wire

@@ rtl/seconds_to_calendar_unit.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_unit
// Converts seconds since 2000-01-01 00:00:00 into time of day and a
// Gregorian date with a shared reciprocal multiplier and one shared 16-bit
// subtract/compare unit.
// ----------------------------------------------------------------------------
// Sequence: reciprocal division (/60, /60, /24), then four-year block steps,
// single-year steps and month steps, then a load of the output register.
// Handshake: a new item is taken only once the last has loaded the output
// register; in_ready is high only between items. The output register lets
// the next item enter while a result waits.
// Reset: arst_n clears the sequencer and out_valid; data registers hold.
`default_nettype none

module seconds_to_calendar_unit
	import stc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [IN_W-1:0]     seconds_since_base,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [SEC_W-1:0]    second_of_minute,
	output      logic [SEC_W-1:0]    minute_of_hour,
	output      logic [HOUR_W-1:0]   hour_of_day,
	output      logic [YEAR_W-1:0]   year_offset,
	output      logic [MONTH_W-1:0]  month_number,
	output      logic [DAY_W-1:0]    day_of_month
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_YR4  = 3'd2;
	localparam logic [2:0] S_YR1  = 3'd3;
	localparam logic [2:0] S_MON  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [1:0] PH_SEC  = 2'd0;
	localparam logic [1:0] PH_MIN  = 2'd1;
	localparam logic [1:0] PH_HOUR = 2'd2;

	logic [2:0]         state_q;
	logic [1:0]         ph_q;
	logic [IN_W-1:0]    work_q;
	logic [SEC_W-1:0]   sec_q;
	logic [SEC_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [DAYS_W-1:0]  days_q;
	logic [YEAR_W-1:0]  year_q;
	logic [MONTH_W-1:0] mon_q;
	logic               out_valid_q;

	logic [SEC_W-1:0]   sec_o_q;
	logic [SEC_W-1:0]   min_o_q;
	logic [HOUR_W-1:0]  hour_o_q;
	logic [YEAR_W-1:0]  year_o_q;
	logic [MONTH_W-1:0] mon_o_q;
	logic [DAY_W-1:0]   day_o_q;

	logic [IN_W-1:0]    magic;
	logic [2*IN_W-1:0]  prod;
	logic [IN_W-1:0]    quo;
	logic [SEC_W-1:0]   rem60;
	logic [HOUR_W-1:0]  rem24;
	logic [ALU_W-1:0]   op_a;
	logic [ALU_W-1:0]   op_b;
	logic [ALU_W:0]     diff;
	logic               borrow;
	logic               leap;
	logic               load_out;

	assign leap  = is_leap(year_q);

	assign magic = (ph_q == PH_HOUR) ? DIV24_MAGIC : DIV60_MAGIC;
	assign prod  = {{IN_W{1'b0}}, work_q} * {{IN_W{1'b0}}, magic};
	assign quo   = (ph_q == PH_HOUR) ? IN_W'(prod >> DIV24_SHIFT)
		: IN_W'(prod >> DIV60_SHIFT);
	assign rem60 = work_q[SEC_W-1:0] + {quo[3:0], 2'b00};
	assign rem24 = work_q[HOUR_W-1:0] + {quo[1:0], 3'b000};

	always_comb begin
		op_a = days_q;
		op_b = month_len(mon_q, leap);
		unique case (state_q)
			S_YR4: begin
				op_b = (year_q == CENTURY_OFF) ? QUAD_DAYS_NOLEAP : QUAD_DAYS;
			end
			S_YR1: begin
				op_b = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
			end
			default: begin
				op_b = month_len(mon_q, leap);
			end
		endcase
	end

	assign diff    = {1'b0, op_a} - {1'b0, op_b};
	assign borrow  = diff[ALU_W];

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_SEC;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV;
						ph_q    <= PH_SEC;
					end
				end
				S_DIV: begin
					unique case (ph_q)
						PH_SEC: begin
							ph_q <= PH_MIN;
						end
						PH_MIN: begin
							ph_q <= PH_HOUR;
						end
						default: begin
							state_q <= S_YR4;
						end
					endcase
				end
				S_YR4: begin
					if (borrow) state_q <= S_YR1;
				end
				S_YR1: begin
					if (borrow) state_q <= S_MON;
				end
				S_MON: begin
					if (borrow || (mon_q == MONTH_DEC)) state_q <= S_DONE;
				end
				default: begin
					if (load_out) state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				work_q <= seconds_since_base;
			end
			S_DIV: begin
				work_q <= quo;
				unique case (ph_q)
					PH_SEC: begin
						sec_q <= rem60;
					end
					PH_MIN: begin
						min_q <= rem60;
					end
					default: begin
						hour_q <= rem24;
						days_q <= quo[DAYS_W-1:0];
						year_q <= '0;
						mon_q  <= '0;
					end
				endcase
			end
			S_YR4: begin
				if (!borrow) begin
					days_q <= diff[DAYS_W-1:0];
					year_q <= year_q + 8'd4;
				end
			end
			S_YR1: begin
				if (!borrow) begin
					days_q <= diff[DAYS_W-1:0];
					year_q <= year_q + 8'd1;
				end
			end
			S_MON: begin
				if (!borrow && (mon_q != MONTH_DEC)) begin
					days_q <= diff[DAYS_W-1:0];
					mon_q  <= mon_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sec_o_q  <= sec_q;
			min_o_q  <= min_q;
			hour_o_q <= hour_q;
			year_o_q <= year_q;
			mon_o_q  <= mon_q + 4'd1;
			day_o_q  <= days_q[DAY_W-1:0] + 5'd1;
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign second_of_minute = sec_o_q;
	assign minute_of_hour   = min_o_q;
	assign hour_of_day      = hour_o_q;
	assign year_offset      = year_o_q;
	assign month_number     = mon_o_q;
	assign day_of_month     = day_o_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("unit ready right after accepting an item");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> ((ph_q == PH_HOUR) ? (rem24 < 5'd24) : (rem60 < 6'd60)))
		else $error("division remainder out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60)
			&& (hour_of_day < 5'd24))
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month_number >= 4'd1) && (month_number <= 4'd12)
			&& (day_of_month >= 5'd1) && (year_offset <= 8'd136))
		else $error("date out of range");

endmodule

`default_nettype wire

@@ bench/seconds_to_calendar_unit_tb.sv @@
// ----------------------------------------------------------------------------
// seconds_to_calendar_unit_tb
// Self-checking bench for the seconds-to-calendar unit. Each accepted item is
// converted to time of day and Gregorian date by a behavioral calendar
// predictor. The expected dates are queued in order, and every accepted result
// is checked field by field. Stimulus covers calendar edges (day, year, leap
// and century rules), the extremes of the 32-bit input, full-range random
// values and random values on year and February boundaries. Both sides idle
// and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_unit_tb
	import stc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DAY_SECONDS  = 86400;
	localparam int unsigned IDLE_LIMIT   = 3000;
	localparam int unsigned TAIL_CYCLES  = 150;

	typedef struct packed {
		logic [SEC_W-1:0]   sec;
		logic [SEC_W-1:0]   minute;
		logic [HOUR_W-1:0]  hour;
		logic [YEAR_W-1:0]  yoff;
		logic [MONTH_W-1:0] mon;
		logic [DAY_W-1:0]   mday;
	} calendar_t;

	logic                clk                = 1'b0;
	logic                arst_n             = 1'b0;
	logic                in_valid           = 1'b0;
	logic                in_ready;
	logic [IN_W-1:0]     seconds_since_base = '0;
	logic                out_valid;
	logic                out_ready          = 1'b0;
	logic [SEC_W-1:0]    second_of_minute;
	logic [SEC_W-1:0]    minute_of_hour;
	logic [HOUR_W-1:0]   hour_of_day;
	logic [YEAR_W-1:0]   year_offset;
	logic [MONTH_W-1:0]  month_number;
	logic [DAY_W-1:0]    day_of_month;

	int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	calendar_t   expected_dates [$];
	calendar_t   head_date;
	int unsigned error_count     = 0;
	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned burst_left      = 0;
	int unsigned idle_cycles     = 0;
	int unsigned rx_cycle        = 0;
	int unsigned rx_hold         = 0;

	seconds_to_calendar_unit DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.seconds_since_base (seconds_since_base),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.second_of_minute   (second_of_minute),
		.minute_of_hour     (minute_of_hour),
		.hour_of_day        (hour_of_day),
		.year_offset        (year_offset),
		.month_number       (month_number),
		.day_of_month       (day_of_month)
	);

	always #5 clk = ~clk;

	function automatic logic leap_offset(input int unsigned yoff);
		int unsigned y;
		y = 2000 + yoff;
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic calendar_t calendar_of(input logic [IN_W-1:0] secs);
		calendar_t   r;
		int unsigned rest;
		int unsigned yoff;
		int unsigned mon;
		int unsigned mlen;
		int unsigned ylen;
		rest     = secs;
		r.sec    = SEC_W'(rest % 60);
		rest     = rest / 60;
		r.minute = SEC_W'(rest % 60);
		rest     = rest / 60;
		r.hour   = HOUR_W'(rest % 24);
		rest     = rest / 24;
		yoff = 0;
		ylen = 366;
		while (rest >= ylen) begin
			rest = rest - ylen;
			yoff++;
			ylen = leap_offset(yoff) ? 366 : 365;
		end
		mon  = 0;
		mlen = month_days[0];
		while (rest >= mlen) begin
			rest = rest - mlen;
			mon++;
			mlen = (mon == 1 && leap_offset(yoff)) ? 29 : month_days[mon];
		end
		r.yoff = YEAR_W'(yoff);
		r.mon  = MONTH_W'(mon + 1);
		r.mday = DAY_W'(rest + 1);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
		error_count++;
	endtask

	task automatic send_seconds(input logic [IN_W-1:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150)
				: $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		in_valid           <= 1'b1;
		seconds_since_base <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_dates.push_back(calendar_of(value));
		items_sent++;
		burst_left--;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_dates.size() != 0) @(posedge clk);
	endtask

	task automatic test_time_of_day();
		send_seconds(32'd0);
		send_seconds(32'd59);
		send_seconds(32'd60);
		send_seconds(32'd3599);
		send_seconds(32'd3600);
		send_seconds(32'd86399);
		send_seconds(32'd86400);
	endtask

	task automatic test_leap_rules();
		// 2000 is leap, 2100 is not, 2104 is again
		send_seconds(IN_W'(64'd58 * DAY_SECONDS + 64'd86399));
		send_seconds(IN_W'(64'd59 * DAY_SECONDS));
		send_seconds(IN_W'(64'd60 * DAY_SECONDS));
		send_seconds(IN_W'(64'd366 * DAY_SECONDS - 64'd1));
		send_seconds(IN_W'(64'd366 * DAY_SECONDS));
		send_seconds(IN_W'(64'd36583 * DAY_SECONDS + 64'd86399));
		send_seconds(IN_W'(64'd36584 * DAY_SECONDS));
		send_seconds(IN_W'(64'd36890 * DAY_SECONDS - 64'd1));
		send_seconds(IN_W'(64'd38044 * DAY_SECONDS));
	endtask

	task automatic test_range_extremes();
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'hFFFF_FFFE);
		send_seconds(32'h8000_0000);
		send_seconds(32'h7FFF_FFFF);
		send_seconds(32'hAAAA_AAAA);
		send_seconds(32'h5555_5555);
		send_seconds(32'd1);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++) send_seconds($urandom);
		drain_results();
		burst_left = 4;
		for (int i = 0; i < 4; i++) send_seconds($urandom);
	endtask

	task automatic test_random_seconds(input int unsigned count);
		// first stretch streams with no gaps
		burst_left = 150;
		for (int unsigned i = 0; i < count; i++) begin
			send_seconds($urandom);
			if (i % 250 == 249) drain_results();
		end
	endtask

	task automatic test_year_boundaries(input int unsigned count);
		int unsigned yoff;
		longint      day;
		longint      secs;
		for (int unsigned i = 0; i < count; i++) begin
			yoff = $urandom_range(0, 136);
			day  = 0;
			for (int unsigned y = 0; y < yoff; y++) day += leap_offset(y) ? 366 : 365;
			case ($urandom_range(0, 4))
				0:       day = (day > 0) ? day - 1 : day;
				1:       day = day;
				2:       day = day + 58;
				3:       day = day + 59;
				default: day = day + $urandom_range(0, 365);
			endcase
			secs = day * DAY_SECONDS;
			case ($urandom_range(0, 2))
				0:       secs = secs;
				1:       secs = secs + DAY_SECONDS - 1;
				default: secs = secs + $urandom_range(0, DAY_SECONDS - 1);
			endcase
			if (secs > 64'hFFFF_FFFF)
				secs = 64'hFFFF_FFFF - $urandom_range(0, 40 * DAY_SECONDS);
			send_seconds(IN_W'(secs));
		end
	endtask

	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (rx_hold != 0) begin
			out_ready <= 1'b0;
			rx_hold   <= rx_hold - 1;
		end else if (rx_cycle[9:8] == 2'd0) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 99) == 0) begin
			out_ready <= 1'b0;
			rx_hold   <= $urandom_range(10, 80);
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_dates.size() == 0) begin
				report_mismatch("result with nothing pending, year_offset", 0, year_offset);
			end else begin
				head_date = expected_dates.pop_front();
				if (second_of_minute !== head_date.sec)
					report_mismatch("second_of_minute", head_date.sec, second_of_minute);
				if (minute_of_hour !== head_date.minute)
					report_mismatch("minute_of_hour", head_date.minute, minute_of_hour);
				if (hour_of_day !== head_date.hour)
					report_mismatch("hour_of_day", head_date.hour, hour_of_day);
				if (year_offset !== head_date.yoff)
					report_mismatch("year_offset", head_date.yoff, year_offset);
				if (month_number !== head_date.mon)
					report_mismatch("month_number", head_date.mon, month_number);
				if (day_of_month !== head_date.mday)
					report_mismatch("day_of_month", head_date.mday, day_of_month);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results pending",
				idle_cycles, expected_dates.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_time_of_day();
		test_leap_rules();
		test_range_extremes();
		test_drain_pause();
		test_random_seconds(1100);
		test_year_boundaries(700);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_dates.size() != 0)
			report_mismatch("results still pending at end", 0, expected_dates.size());
		$display("covered %0d conversions: day, year, leap and century edges,", items_sent);
		$display("input extremes, full-range and boundary random values; %0d checked",
			results_checked);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
rtl/stc_pkg.sv
rtl/seconds_to_calendar_unit.sv
bench/seconds_to_calendar_unit_tb.sv
